// ===== hdl/mep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mep_pkg;

  localparam int RADIUS_BITS_DEF = 10;

  typedef enum logic [4:0] {
    OP_NONE   = 5'd0,
    OP_LOAD   = 5'd1,
    OP_SQ_RX  = 5'd2,
    OP_SQ_RY  = 5'd3,
    OP_DY0    = 5'd4,
    OP_DEC0   = 5'd5,
    OP_RC1    = 5'd6,
    OP_RC2    = 5'd7,
    OP_RC3    = 5'd8,
    OP_RC4    = 5'd9,
    OP_RC5    = 5'd10,
    OP_RC6    = 5'd11,
    OP_RC7    = 5'd12,
    OP_EMIT   = 5'd13,
    OP_STEP   = 5'd14,
    OP_MUL_DX = 5'd15,
    OP_MUL_DY = 5'd16,
    OP_SET_DX = 5'd17,
    OP_SET_DY = 5'd18,
    OP_DECU   = 5'd19
  } mep_op_t;

  typedef struct packed {
    mep_op_t    op;
    logic [1:0] quad;
  } mep_cmd_t;

  typedef struct packed {
    logic busy;
    logic region_two;
    logic region_change;
    logic y_zero;
    logic skip;
    logic out_free;
  } mep_status_t;

endpackage

`default_nettype wire

// ===== hdl/mep_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mep_ctrl import mep_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_kind,
  output logic             in_tready,
  input  wire mep_status_t status,
  output mep_cmd_t         cmd
);

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_SQ_RX  = 19'h00002,
    S_SQ_RY  = 19'h00004,
    S_DY0    = 19'h00008,
    S_DEC0   = 19'h00010,
    S_RC1    = 19'h00020,
    S_RC2    = 19'h00040,
    S_RC3    = 19'h00080,
    S_RC4    = 19'h00100,
    S_RC5    = 19'h00200,
    S_RC6    = 19'h00400,
    S_RC7    = 19'h00800,
    S_EMIT   = 19'h01000,
    S_STEP   = 19'h02000,
    S_MUL1   = 19'h04000,
    S_SET1   = 19'h08000,
    S_MUL2   = 19'h10000,
    S_SET2   = 19'h20000,
    S_DECU   = 19'h40000
  } mep_state_t;

  mep_state_t state_r, state_nxt;
  logic [1:0] quad_r, quad_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    quad_nxt  = quad_r;
    cmd.op    = OP_NONE;
    cmd.quad  = quad_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (!in_kind) begin
            cmd.op    = OP_LOAD;
            state_nxt = S_SQ_RX;
          end else if (status.busy) begin
            state_nxt = status.region_change ? S_RC1 : S_EMIT;
          end
        end
      end
      S_SQ_RX: begin
        cmd.op    = OP_SQ_RX;
        state_nxt = S_SQ_RY;
      end
      S_SQ_RY: begin
        cmd.op    = OP_SQ_RY;
        state_nxt = S_DY0;
      end
      S_DY0: begin
        cmd.op    = OP_DY0;
        state_nxt = S_DEC0;
      end
      S_DEC0: begin
        cmd.op    = OP_DEC0;
        state_nxt = S_IDLE;
      end
      S_RC1: begin
        cmd.op    = OP_RC1;
        state_nxt = S_RC2;
      end
      S_RC2: begin
        cmd.op    = OP_RC2;
        state_nxt = S_RC3;
      end
      S_RC3: begin
        cmd.op    = OP_RC3;
        state_nxt = S_RC4;
      end
      S_RC4: begin
        cmd.op    = OP_RC4;
        state_nxt = S_RC5;
      end
      S_RC5: begin
        cmd.op    = OP_RC5;
        state_nxt = S_RC6;
      end
      S_RC6: begin
        cmd.op    = OP_RC6;
        state_nxt = S_RC7;
      end
      S_RC7: begin
        cmd.op    = OP_RC7;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op   = OP_EMIT;
          quad_nxt = quad_r + 2'd1;
          if (quad_r == 2'd3) begin
            state_nxt = S_STEP;
          end
        end
      end
      S_STEP: begin
        cmd.op    = OP_STEP;
        state_nxt = (status.region_two && status.y_zero) ? S_IDLE : S_MUL1;
      end
      S_MUL1: begin
        cmd.op    = status.region_two ? OP_MUL_DY : OP_MUL_DX;
        state_nxt = S_SET1;
      end
      S_SET1: begin
        cmd.op    = status.region_two ? OP_SET_DY : OP_SET_DX;
        state_nxt = status.skip ? S_DECU : S_MUL2;
      end
      S_MUL2: begin
        cmd.op    = status.region_two ? OP_MUL_DX : OP_MUL_DY;
        state_nxt = S_SET2;
      end
      S_SET2: begin
        cmd.op    = status.region_two ? OP_SET_DX : OP_SET_DY;
        state_nxt = S_DECU;
      end
      S_DECU: begin
        cmd.op    = OP_DECU;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      quad_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      quad_r  <= quad_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mep_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mep_dpath import mep_pkg::*; #(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mep_cmd_t                      cmd,
  input  wire logic [RADIUS_BITS-1:0]        in_rx,
  input  wire logic [RADIUS_BITS-1:0]        in_ry,
  input  wire logic                          out_tready,
  output logic                               out_tvalid,
  output logic signed [RADIUS_BITS:0]        out_px,
  output logic signed [RADIUS_BITS:0]        out_py,
  output logic                               out_last,
  output logic                               out_done,
  output mep_status_t                        status
);

  localparam int R  = RADIUS_BITS;
  localparam int CW = R + 1;
  localparam int SW = 2 * R;
  localparam int TW = 3 * R + 2;
  localparam int AW = 3 * R + 1;
  localparam int BW = R + 1;
  localparam int PW = AW + BW;
  localparam int DW = 4 * R + 8;

  logic [R-1:0]  rx_r, rx_nxt, ry_r, ry_nxt;
  logic [SW-1:0] rxsq_r, rxsq_nxt, rysq_r, rysq_nxt;
  logic [R-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic [TW-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [DW-1:0] dec_r, dec_nxt, acc_r, acc_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic          reg2_r, reg2_nxt, busy_r, busy_nxt, out_valid_r, out_valid_nxt;
  logic [CW-1:0] px_r, px_nxt, py_r, py_nxt;
  logic          last_r, last_nxt, done_r, done_nxt;

  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [BW-1:0] tx;
  logic [R-1:0]  ty;
  logic          dec_neg, dec_pos, y_zero, use_dx, use_dy;
  logic [DW-1:0] add_dx, sub_dy, add_sq;

  assign tx      = {x_r, 1'b1};
  assign y_zero  = (y_r == '0);
  assign ty      = y_zero ? R'(1) : (y_r - R'(1));
  assign dec_neg = dec_r[DW-1];
  assign dec_pos = (dec_r != '0) && !dec_neg;

  assign use_dx = !(reg2_r && dec_pos);
  assign use_dy = !(!reg2_r && dec_neg);
  assign add_dx = use_dx ? DW'({dx_r, 2'b00}) : '0;
  assign sub_dy = use_dy ? DW'({dy_r, 2'b00}) : '0;
  assign add_sq = reg2_r ? DW'({rxsq_r, 2'b00}) : DW'({rysq_r, 2'b00});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SQ_RX: begin
        mul_a = AW'(rx_r);
        mul_b = BW'(rx_r);
      end
      OP_SQ_RY: begin
        mul_a = AW'(ry_r);
        mul_b = BW'(ry_r);
      end
      OP_DY0: begin
        mul_a = AW'(rxsq_r);
        mul_b = BW'(ry_r);
      end
      OP_RC1: begin
        mul_a = AW'(rysq_r);
        mul_b = tx;
      end
      OP_RC2: begin
        mul_a = prod_r[AW-1:0];
        mul_b = tx;
      end
      OP_RC3: begin
        mul_a = AW'(rxsq_r);
        mul_b = BW'(ty);
      end
      OP_RC4: begin
        mul_a = prod_r[AW-1:0];
        mul_b = BW'(ty);
      end
      OP_RC5: begin
        mul_a = AW'(rxsq_r);
        mul_b = BW'(ry_r);
      end
      OP_RC6: begin
        mul_a = prod_r[AW-1:0];
        mul_b = BW'(ry_r);
      end
      OP_MUL_DX: begin
        mul_a = AW'(rysq_r);
        mul_b = BW'(x_r);
      end
      OP_MUL_DY: begin
        mul_a = AW'(rxsq_r);
        mul_b = BW'(y_r);
      end
      default: begin
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    rxsq_nxt      = rxsq_r;
    rysq_nxt      = rysq_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dec_nxt       = dec_r;
    acc_nxt       = acc_r;
    reg2_nxt      = reg2_r;
    busy_nxt      = busy_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    last_nxt      = last_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (cmd.op)
      OP_LOAD: begin
        rx_nxt   = in_rx;
        ry_nxt   = in_ry;
        x_nxt    = '0;
        y_nxt    = in_ry;
        dx_nxt   = '0;
        reg2_nxt = 1'b0;
        busy_nxt = 1'b1;
      end
      OP_SQ_RY: begin
        rxsq_nxt = prod_r[SW-1:0];
      end
      OP_DY0: begin
        rysq_nxt = prod_r[SW-1:0];
      end
      OP_DEC0: begin
        dy_nxt  = {prod_r[TW-2:0], 1'b0};
        dec_nxt = DW'({rysq_r, 2'b00}) + DW'(rxsq_r) - DW'({prod_r, 2'b00});
      end
      OP_RC3: begin
        acc_nxt = DW'(prod_r);
      end
      OP_RC5: begin
        acc_nxt = acc_r + DW'({prod_r, 2'b00});
      end
      OP_RC7: begin
        dec_nxt  = acc_r - DW'({prod_r, 2'b00});
        reg2_nxt = 1'b1;
      end
      OP_EMIT: begin
        px_nxt        = cmd.quad[0] ? (CW'(0) - CW'(x_r)) : CW'(x_r);
        py_nxt        = cmd.quad[1] ? (CW'(0) - CW'(y_r)) : CW'(y_r);
        last_nxt      = (cmd.quad == 2'd3);
        done_nxt      = reg2_r && y_zero;
        out_valid_nxt = 1'b1;
      end
      OP_STEP: begin
        if (reg2_r) begin
          if (y_zero) begin
            busy_nxt = 1'b0;
          end else begin
            y_nxt = y_r - R'(1);
            if (!dec_pos) begin
              x_nxt = x_r + R'(1);
            end
          end
        end else begin
          x_nxt = x_r + R'(1);
          if (!dec_neg && !y_zero) begin
            y_nxt = y_r - R'(1);
          end
        end
      end
      OP_SET_DX: begin
        dx_nxt = {prod_r[TW-2:0], 1'b0};
      end
      OP_SET_DY: begin
        dy_nxt = {prod_r[TW-2:0], 1'b0};
      end
      OP_DECU: begin
        dec_nxt = dec_r + add_dx - sub_dy + add_sq;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg2_r      <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      reg2_r      <= reg2_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    rxsq_r <= rxsq_nxt;
    rysq_r <= rysq_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    dec_r  <= dec_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
  end

  assign status.busy          = busy_r;
  assign status.region_two    = reg2_r;
  assign status.region_change = !reg2_r && (dx_r >= dy_r);
  assign status.y_zero        = y_zero;
  assign status.skip          = reg2_r ? dec_pos : dec_neg;
  assign status.out_free      = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_px     = px_r;
  assign out_py     = py_r;
  assign out_last   = last_r;
  assign out_done   = done_r;

endmodule

`default_nettype wire

// ===== hdl/midpoint_ellipse_points_top.sv =====
// Start word: taken when idle; states SQ_RX, SQ_RY, DY0 and DEC0 then run before the next
// word is taken. Advance word (ignored unless a curve is busy): 4 output words, each issued
// as the output register frees, after states RC1..RC7 on a step entering region 2, then step
// and delta updates; one shared multiplier and the one-word output register set the pace.
// Reset: synchronous, active low; clears the sequencer, the output valid and the busy flag.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_ellipse_points_top import mep_pkg::*; #(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  localparam int IN_W  = ((2 * RADIUS_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * (RADIUS_BITS + 1) + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // radius_x, radius_y
  input  wire logic             in_tuser,   // kind
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // point_x, point_y
  output logic                  out_tlast,  // last_in_step
  output logic                  out_tuser   // curve_done
);

  localparam int R = RADIUS_BITS;

  mep_cmd_t    cmd;
  mep_status_t status;
  logic signed [R:0] px, py;

  mep_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mep_dpath #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_rx      (in_tdata[R-1:0]),
    .in_ry      (in_tdata[2*R-1:R]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_px     (px),
    .out_py     (py),
    .out_last   (out_tlast),
    .out_done   (out_tuser),
    .status     (status)
  );

  assign out_tdata = OUT_W'({py, px});

endmodule

`default_nettype wire
